[rtl/sip_non_invite_client_transaction_assert.svh]
// Assertion macros shared by the non-INVITE client transaction RTL
`ifndef SIP_NON_INVITE_CLIENT_TRANSACTION_ASSERT_SVH
`define SIP_NON_INVITE_CLIENT_TRANSACTION_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset
`define SNC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sip nict assertion failed");

// Next-cycle implication, checked on every clock outside reset
`define SNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sip nict assertion failed");

`endif

[rtl/sip_nict_pkg.sv]
// Shared types and constants of the SIP non-INVITE client transaction block
package sip_nict_pkg;

    // event opcodes on the input side
    localparam logic [2:0] OP_MESSAGE  = 3'd0;
    localparam logic [2:0] OP_LIFESPAN = 3'd1;
    localparam logic [2:0] OP_TIMER_E  = 3'd2;
    localparam logic [2:0] OP_TIMER_F  = 3'd3;
    localparam logic [2:0] OP_TIMER_K  = 3'd4;

    // transaction state codes as reported on new_state
    localparam logic [2:0] TXN_IDLE       = 3'd0;
    localparam logic [2:0] TXN_TRYING     = 3'd1;
    localparam logic [2:0] TXN_PROCEEDING = 3'd2;
    localparam logic [2:0] TXN_COMPLETED  = 3'd3;
    localparam logic [2:0] TXN_TERMINATED = 3'd4;

    // configuration register indexes and reset values
    localparam logic [1:0]  REG_T1      = 2'd0;
    localparam logic [1:0]  REG_T2      = 2'd1;
    localparam logic [1:0]  REG_USE_K   = 2'd2;
    localparam logic [15:0] T1_RESET    = 16'd500;
    localparam logic [15:0] T2_RESET    = 16'd4000;
    localparam logic        USE_K_RESET = 1'b1;

    // default depth of the queue between classifier and executor
    localparam int QUEUE_DEPTH_DEF = 2;

    // classified event kinds
    typedef enum logic [3:0] {
        EV_IGNORE,
        EV_RX_REQ,
        EV_TX_REQ,
        EV_TX_FINAL,
        EV_RX_FINAL,
        EV_RX_PROV,
        EV_LIFESPAN,
        EV_TIMER_E,
        EV_TIMER_F,
        EV_TIMER_K
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind   kind;
        logic [16:0] dbl_ms;   // twice the fired timer E interval
    } t_evt;

    typedef struct packed {
        logic [15:0] t1_ms;
        logic [15:0] t2_ms;
        logic        use_timer_k;
    } t_cfg;

    typedef struct packed {
        logic        send_to_transport;
        logic        deliver_to_user;
        logic        report_timeout;
        logic        start_retx_timer;
        logic [15:0] retx_interval_ms;
        logic        stop_retx_timer;
        logic        start_timeout_timer;
        logic        stop_timeout_timer;
        logic        start_linger_timer;
        logic        terminate_now;
        logic [2:0]  new_state;
    } t_action;

endpackage

[rtl/sip_non_invite_client_transaction.sv]
// SIP non-INVITE client transaction controller: top level with register port
// One action word comes out for every event beat taken in. Events are
// accepted at one per clock while full is low; the executor's state register
// updates at most once per clock, which sets that rate. A beat taken in
// passes the classifier register, then the queue, then the output register
// before its action word shows. full rises only when the queue and
// the classifier register are both occupied behind a stalled output.
// Registers t1_ms (0x0), t2_ms (0x4) and use_timer_k (0x8) should be
// written only while no event is in flight.
`include "sip_non_invite_client_transaction_assert.svh"

module sip_non_invite_client_transaction
    import sip_nict_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // event side
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_opcode,
    input  logic        i_is_send,
    input  logic        i_is_request,
    input  logic        i_is_provisional,
    input  logic [15:0] i_fired_interval_ms,
    // action side
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_send_to_transport,
    output logic        o_deliver_to_user,
    output logic        o_report_timeout,
    output logic        o_start_retx_timer,
    output logic [15:0] o_retx_interval_ms,
    output logic        o_stop_retx_timer,
    output logic        o_start_timeout_timer,
    output logic        o_stop_timeout_timer,
    output logic        o_start_linger_timer,
    output logic        o_terminate_now,
    output logic [2:0]  o_new_state
);

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       cfg_wr;
    logic       f_valid;
    t_evt       f_evt;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;
    t_evt       q_evt;
    t_action    act;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.t1_ms       <= T1_RESET;
            r_cfg.t2_ms       <= T2_RESET;
            r_cfg.use_timer_k <= USE_K_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_T1:    r_cfg.t1_ms       <= pwdata[15:0];
                REG_T2:    r_cfg.t2_ms       <= pwdata[15:0];
                REG_USE_K: r_cfg.use_timer_k <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_T1:    prdata = {16'd0, r_cfg.t1_ms};
            REG_T2:    prdata = {16'd0, r_cfg.t2_ms};
            REG_USE_K: prdata = {31'd0, r_cfg.use_timer_k};
            default:   prdata = '0;
        endcase
    end

    sip_nict_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (i_push),
        .o_full              (o_full),
        .i_opcode            (i_opcode),
        .i_is_send           (i_is_send),
        .i_is_request        (i_is_request),
        .i_is_provisional    (i_is_provisional),
        .i_fired_interval_ms (i_fired_interval_ms),
        .o_valid             (f_valid),
        .o_evt               (f_evt),
        .i_q_ready           (q_ready)
    );

    sip_nict_fifo #(
        .WIDTH ($bits(t_evt)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_evt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_evt),
        .i_pop   (q_pop)
    );

    sip_nict_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_evt     (q_evt),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_act     (act)
    );

    // action word fields
    assign o_send_to_transport   = act.send_to_transport;
    assign o_deliver_to_user     = act.deliver_to_user;
    assign o_report_timeout      = act.report_timeout;
    assign o_start_retx_timer    = act.start_retx_timer;
    assign o_retx_interval_ms    = act.retx_interval_ms;
    assign o_stop_retx_timer     = act.stop_retx_timer;
    assign o_start_timeout_timer = act.start_timeout_timer;
    assign o_stop_timeout_timer  = act.stop_timeout_timer;
    assign o_start_linger_timer  = act.start_linger_timer;
    assign o_terminate_now       = act.terminate_now;
    assign o_new_state           = act.new_state;

    // checks on the action word and on the queue path
    `SNC_ASSERT_NOW(a_ival_zero_when_idle, !o_empty && !o_start_retx_timer, o_retx_interval_ms == 16'd0)
    `SNC_ASSERT_NOW(a_term_state, !o_empty && o_terminate_now, o_new_state == TXN_TERMINATED)
    `SNC_ASSERT_NOW(a_linger_state, !o_empty && o_start_linger_timer, o_new_state == TXN_COMPLETED)
    `SNC_ASSERT_NEXT(a_queue_fed, f_valid && q_ready, q_valid)

endmodule

[rtl/sip_nict_fifo.sv]
// Small register queue between the event classifier and the executor
module sip_nict_fifo
    import sip_nict_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/sip_nict_front.sv]
// Input stage: accepts event beats and classifies them into event kinds
module sip_nict_front
    import sip_nict_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_opcode,
    input  logic        i_is_send,
    input  logic        i_is_request,
    input  logic        i_is_provisional,
    input  logic [15:0] i_fired_interval_ms,
    output logic        o_valid,
    output t_evt        o_evt,
    input  logic        i_q_ready
);

    logic      r_valid;
    t_evt      r_evt;
    t_evt      n_evt;
    logic      ready;
    t_evt_kind msg_kind;

    assign ready   = !r_valid || i_q_ready;
    assign o_full  = !ready;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    // message descriptor decode
    always_comb begin
        msg_kind = EV_IGNORE;
        if (i_is_request) begin
            msg_kind = i_is_send ? EV_TX_REQ : EV_RX_REQ;
        end else if (!i_is_provisional) begin
            msg_kind = i_is_send ? EV_TX_FINAL : EV_RX_FINAL;
        end else if (!i_is_send) begin
            msg_kind = EV_RX_PROV;
        end
    end

    // opcode decode
    always_comb begin
        n_evt.dbl_ms = {i_fired_interval_ms, 1'b0};
        unique case (i_opcode)
            OP_MESSAGE:  n_evt.kind = msg_kind;
            OP_LIFESPAN: n_evt.kind = EV_LIFESPAN;
            OP_TIMER_E:  n_evt.kind = EV_TIMER_E;
            OP_TIMER_F:  n_evt.kind = EV_TIMER_F;
            OP_TIMER_K:  n_evt.kind = EV_TIMER_K;
            default:     n_evt.kind = EV_IGNORE;
        endcase
    end

    // holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && ready) begin
            r_evt <= n_evt;
        end
    end

endmodule

[rtl/sip_nict_back.sv]
// Executor: transaction state machine and the registered action word
module sip_nict_back
    import sip_nict_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_evt    i_evt,
    output logic    o_q_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_action o_act
);

    typedef enum logic [2:0] {
        ST_IDLE       = TXN_IDLE,
        ST_TRYING     = TXN_TRYING,
        ST_PROCEEDING = TXN_PROCEEDING,
        ST_COMPLETED  = TXN_COMPLETED,
        ST_TERMINATED = TXN_TERMINATED
    } t_txn_state;

    t_txn_state r_state;
    t_txn_state n_state;
    logic       r_init;
    logic       n_init;
    logic       r_out_valid;
    t_action    r_act;
    t_action    n_act;
    logic       take;
    logic       active;
    logic       do_final;

    assign take    = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop = take;
    assign o_empty = !r_out_valid;
    assign o_act   = r_act;
    assign active  = (r_state == ST_TRYING) || (r_state == ST_PROCEEDING);

    // next state and action word for the event at the queue head
    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_act    = '0;
        do_final = 1'b0;
        unique case (i_evt.kind)
            EV_RX_REQ: begin
                n_act.send_to_transport = (r_state == ST_IDLE);
            end
            EV_TX_REQ: begin
                if (r_state == ST_IDLE && !r_init) begin
                    n_init                    = 1'b1;
                    n_state                   = ST_TRYING;
                    n_act.start_retx_timer    = 1'b1;
                    n_act.retx_interval_ms    = i_cfg.t1_ms;
                    n_act.start_timeout_timer = 1'b1;
                end
            end
            EV_TX_FINAL: begin
                do_final = (r_state == ST_IDLE);
            end
            EV_RX_FINAL: begin
                do_final = (r_state == ST_IDLE) || active;
            end
            EV_RX_PROV: begin
                if (active) begin
                    n_state               = ST_PROCEEDING;
                    n_act.deliver_to_user = 1'b1;
                end
            end
            EV_LIFESPAN: begin
                n_state              = ST_TERMINATED;
                n_act.report_timeout = 1'b1;
                n_act.terminate_now  = 1'b1;
            end
            EV_TIMER_E: begin
                if (active) begin
                    n_act.send_to_transport = 1'b1;
                    n_act.start_retx_timer  = 1'b1;
                    // proceeding restarts at the cap, trying doubles up to it
                    if (r_state == ST_PROCEEDING || i_evt.dbl_ms > {1'b0, i_cfg.t2_ms}) begin
                        n_act.retx_interval_ms = i_cfg.t2_ms;
                    end else begin
                        n_act.retx_interval_ms = i_evt.dbl_ms[15:0];
                    end
                end
            end
            EV_TIMER_F: begin
                if (active) begin
                    n_state               = ST_TERMINATED;
                    n_act.stop_retx_timer = 1'b1;
                    n_act.report_timeout  = 1'b1;
                    n_act.terminate_now   = 1'b1;
                end
            end
            EV_TIMER_K: begin
                n_state             = ST_TERMINATED;
                n_act.terminate_now = 1'b1;
            end
            default: begin
            end
        endcase

        // final response closes the transaction
        if (do_final) begin
            n_act.stop_retx_timer    = 1'b1;
            n_act.stop_timeout_timer = 1'b1;
            n_act.deliver_to_user    = 1'b1;
            if (i_cfg.use_timer_k) begin
                n_state                  = ST_COMPLETED;
                n_act.start_linger_timer = 1'b1;
            end else begin
                n_state             = ST_TERMINATED;
                n_act.terminate_now = 1'b1;
            end
        end
        n_act.new_state = n_state;
    end

    // state, sent flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_out_valid <= 1'b1;
            r_act       <= n_act;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench for the SIP non-INVITE client transaction block: walks one transaction end to end
module tb_top;
    import sip_nict_pkg::*;

    // opcodes above timer K that the block must ignore
    localparam logic [2:0] OP_OTHER_LO = 3'd5;
    localparam logic [2:0] OP_OTHER_HI = 3'd7;

    // ways the transaction may be closed; the seed picks one per run
    localparam int END_VIA_LINGER = 0;
    localparam int END_NO_LINGER  = 1;
    localparam int END_TIMER_F    = 2;
    localparam int END_LIFESPAN   = 3;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        is_send;
        logic        is_request;
        logic        is_provisional;
        logic [15:0] fired_ms;
    } t_evt_item;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [2:0]  i_opcode = '0;
    logic        i_is_send = 1'b0;
    logic        i_is_request = 1'b0;
    logic        i_is_provisional = 1'b0;
    logic [15:0] i_fired_interval_ms = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic        o_send_to_transport;
    logic        o_deliver_to_user;
    logic        o_report_timeout;
    logic        o_start_retx_timer;
    logic [15:0] o_retx_interval_ms;
    logic        o_stop_retx_timer;
    logic        o_start_timeout_timer;
    logic        o_stop_timeout_timer;
    logic        o_start_linger_timer;
    logic        o_terminate_now;
    logic [2:0]  o_new_state;

    // predictor copy of the registers and the transaction state
    logic [15:0] cfg_t1 = T1_RESET;
    logic [15:0] cfg_t2 = T2_RESET;
    logic        cfg_use_k = USE_K_RESET;
    logic [2:0]  txn_st = TXN_IDLE;
    logic        sent_flag = 1'b0;

    t_evt_item   pending_events[$];
    t_action     expected_actions[$];
    logic        tx_active = 1'b0;
    logic        hold_tx = 1'b0;
    int          tx_gap = 0;
    int          tx_burst = 0;
    int          rx_gap = 0;
    int          rx_burst = 0;
    int          errors = 0;
    int unsigned cycle_count = 0;

    sip_non_invite_client_transaction dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_push                (i_push),
        .o_full                (o_full),
        .i_opcode              (i_opcode),
        .i_is_send             (i_is_send),
        .i_is_request          (i_is_request),
        .i_is_provisional      (i_is_provisional),
        .i_fired_interval_ms   (i_fired_interval_ms),
        .o_empty               (o_empty),
        .i_pop                 (i_pop),
        .o_send_to_transport   (o_send_to_transport),
        .o_deliver_to_user     (o_deliver_to_user),
        .o_report_timeout      (o_report_timeout),
        .o_start_retx_timer    (o_start_retx_timer),
        .o_retx_interval_ms    (o_retx_interval_ms),
        .o_stop_retx_timer     (o_stop_retx_timer),
        .o_start_timeout_timer (o_start_timeout_timer),
        .o_stop_timeout_timer  (o_stop_timeout_timer),
        .o_start_linger_timer  (o_start_linger_timer),
        .o_terminate_now       (o_terminate_now),
        .o_new_state           (o_new_state)
    );

    always #5 i_clk = ~i_clk;

    // final response: stop E and F, deliver, then linger in completed or terminate
    function automatic t_action final_resp_action();
        t_action a;
        a = '0;
        a.stop_retx_timer    = 1'b1;
        a.stop_timeout_timer = 1'b1;
        a.deliver_to_user    = 1'b1;
        if (cfg_use_k) begin
            txn_st = TXN_COMPLETED;
            a.start_linger_timer = 1'b1;
        end else begin
            txn_st = TXN_TERMINATED;
            a.terminate_now = 1'b1;
        end
        return a;
    endfunction

    // action word for one event; advances the predicted transaction state
    function automatic t_action nict_next_action(input t_evt_item ev);
        t_action     a;
        logic [16:0] dbl;
        a = '0;
        dbl = {ev.fired_ms, 1'b0};
        case (ev.opcode)
            OP_MESSAGE: begin
                case (txn_st)
                    TXN_IDLE: begin
                        if (!ev.is_send && ev.is_request) begin
                            a.send_to_transport = 1'b1;
                        end else if (ev.is_send && ev.is_request && !sent_flag) begin
                            sent_flag = 1'b1;
                            txn_st = TXN_TRYING;
                            a.start_retx_timer    = 1'b1;
                            a.retx_interval_ms    = cfg_t1;
                            a.start_timeout_timer = 1'b1;
                        end else if (!ev.is_request && !ev.is_provisional) begin
                            a = final_resp_action();
                        end
                    end
                    TXN_TRYING, TXN_PROCEEDING: begin
                        if (!ev.is_send && !ev.is_request) begin
                            if (ev.is_provisional) begin
                                txn_st = TXN_PROCEEDING;
                                a.deliver_to_user = 1'b1;
                            end else begin
                                a = final_resp_action();
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_LIFESPAN: begin
                txn_st = TXN_TERMINATED;
                a.report_timeout = 1'b1;
                a.terminate_now  = 1'b1;
            end
            OP_TIMER_E: begin
                if (txn_st == TXN_TRYING) begin
                    a.send_to_transport = 1'b1;
                    a.start_retx_timer  = 1'b1;
                    a.retx_interval_ms  = (dbl > {1'b0, cfg_t2}) ? cfg_t2 : dbl[15:0];
                end else if (txn_st == TXN_PROCEEDING) begin
                    a.send_to_transport = 1'b1;
                    a.start_retx_timer  = 1'b1;
                    a.retx_interval_ms  = cfg_t2;
                end
            end
            OP_TIMER_F: begin
                if (txn_st == TXN_TRYING || txn_st == TXN_PROCEEDING) begin
                    txn_st = TXN_TERMINATED;
                    a.stop_retx_timer = 1'b1;
                    a.report_timeout  = 1'b1;
                    a.terminate_now   = 1'b1;
                end
            end
            OP_TIMER_K: begin
                txn_st = TXN_TERMINATED;
                a.terminate_now = 1'b1;
            end
            default: ;
        endcase
        a.new_state = txn_st;
        return a;
    endfunction

    // idle length: mostly short, a few long, with occasional runs of none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_evt_item make_item(input logic [2:0] op, input logic snd,
                                            input logic req, input logic prov,
                                            input logic [15:0] fired);
        t_evt_item ev;
        ev.opcode         = op;
        ev.is_send        = snd;
        ev.is_request     = req;
        ev.is_provisional = prov;
        ev.fired_ms       = fired;
        return ev;
    endfunction

    // timer E intervals clustered around the point where doubling meets t2
    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 16'($urandom);
        if (r < 45) return 16'($urandom_range(0, 15));
        if (r < 65) return {1'b0, cfg_t2[15:1]} + 16'($urandom_range(0, 1));
        if (r < 75) return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        return 16'($urandom_range(0, 8191));
    endfunction

    // events while trying or proceeding that keep the transaction alive
    function automatic t_evt_item live_event(input logic allow_prov);
        int   r;
        logic snd;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return make_item(OP_TIMER_E, 1'($urandom), 1'($urandom), 1'($urandom),
                             pick_interval());
        end
        if (r < 70 || (r < 82 && !allow_prov)) begin
            // sent events and requests are ignored here
            snd = 1'($urandom);
            return make_item(OP_MESSAGE, snd, snd ? 1'($urandom) : 1'b1, 1'($urandom),
                             16'($urandom));
        end
        if (r < 82) return make_item(OP_MESSAGE, 1'b0, 1'b0, 1'b1, 16'($urandom));
        return make_item(3'($urandom_range(OP_OTHER_LO, OP_OTHER_HI)), 1'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom));
    endfunction

    // events that completed absorbs: messages, E, F and unknown timers
    function automatic t_evt_item absorbed_event();
        int         r;
        logic [2:0] op;
        r = $urandom_range(0, 5);
        if (r < 3) op = OP_MESSAGE;
        else if (r == 3) op = OP_TIMER_E;
        else if (r == 4) op = OP_TIMER_F;
        else op = 3'($urandom_range(OP_OTHER_LO, OP_OTHER_HI));
        return make_item(op, 1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endfunction

    // event driver: one beat per accepted push, random gaps between beats
    always @(posedge i_clk) begin
        t_evt_item nxt;
        if (!i_rst_n) begin
            i_push <= 1'b0;
            tx_active = 1'b0;
        end else begin
            if (i_push && !o_full) begin
                expected_actions.push_back(nict_next_action({i_opcode, i_is_send, i_is_request,
                                                             i_is_provisional,
                                                             i_fired_interval_ms}));
                tx_active = 1'b0;
            end
            if (!tx_active) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (!hold_tx && pending_events.size() != 0) begin
                    nxt = pending_events.pop_front();
                    {i_opcode, i_is_send, i_is_request, i_is_provisional,
                     i_fired_interval_ms} <= nxt;
                    tx_active = 1'b1;
                    tx_gap = pick_gap(tx_burst);
                end
            end
            i_push <= tx_active;
        end
    end

    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // action monitor: checks every popped beat against the oldest expectation
    always @(posedge i_clk) begin
        t_action got;
        t_action want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                got = {o_send_to_transport, o_deliver_to_user, o_report_timeout,
                       o_start_retx_timer, o_retx_interval_ms, o_stop_retx_timer,
                       o_start_timeout_timer, o_stop_timeout_timer, o_start_linger_timer,
                       o_terminate_now, o_new_state};
                if (expected_actions.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected action beat: expected none, actual %h",
                                 $time, got);
                end else begin
                    want = expected_actions.pop_front();
                    cmp_field("send_to_transport", 16'(want.send_to_transport),
                              16'(got.send_to_transport));
                    cmp_field("deliver_to_user", 16'(want.deliver_to_user),
                              16'(got.deliver_to_user));
                    cmp_field("report_timeout", 16'(want.report_timeout),
                              16'(got.report_timeout));
                    cmp_field("start_retx_timer", 16'(want.start_retx_timer),
                              16'(got.start_retx_timer));
                    cmp_field("retx_interval_ms", want.retx_interval_ms,
                              got.retx_interval_ms);
                    cmp_field("stop_retx_timer", 16'(want.stop_retx_timer),
                              16'(got.stop_retx_timer));
                    cmp_field("start_timeout_timer", 16'(want.start_timeout_timer),
                              16'(got.start_timeout_timer));
                    cmp_field("stop_timeout_timer", 16'(want.stop_timeout_timer),
                              16'(got.stop_timeout_timer));
                    cmp_field("start_linger_timer", 16'(want.start_linger_timer),
                              16'(got.start_linger_timer));
                    cmp_field("terminate_now", 16'(want.terminate_now),
                              16'(got.terminate_now));
                    cmp_field("new_state", 16'(want.new_state), 16'(got.new_state));
                end
                rx_gap = pick_gap(rx_burst);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one register transfer: setup, then access until pready
    task automatic reg_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] reg_image(input logic [1:0] idx);
        case (idx)
            REG_T1:    return {16'h0000, cfg_t1};
            REG_T2:    return {16'h0000, cfg_t2};
            REG_USE_K: return {31'h0, cfg_use_k};
            default:   return '0;
        endcase
    endfunction

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;
        reg_access(idx, 1'b0, '0, rd);
        if (rd !== reg_image(idx)) begin
            errors++;
            $display("%0t: register %0d readback mismatch: expected %0h, actual %0h",
                     $time, idx, reg_image(idx), rd);
        end
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused_rd;
        reg_access(idx, 1'b1, value, unused_rd);
        case (idx)
            REG_T1:    cfg_t1 = value[15:0];
            REG_T2:    cfg_t2 = value[15:0];
            REG_USE_K: cfg_use_k = value[0];
            default: ;
        endcase
        check_reg(idx);
    endtask

    // idle means nothing queued, nothing on the push side, nothing owed
    task automatic wait_for_drain();
        while (pending_events.size() != 0 || tx_active || expected_actions.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int          end_path;
        logic [15:0] t2_walk[4];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_reg(REG_T1);
        check_reg(REG_T2);
        check_reg(REG_USE_K);

        // idle: received requests go to transport, the rest is ignored
        pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b1, 1'b0, 16'h0000));
        pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b1, 1'b1, 16'hffff));
        pending_events.push_back(make_item(OP_MESSAGE, 1'b1, 1'b0, 1'b1, 16'h0000));
        pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b0, 1'b1, 16'hffff));
        pending_events.push_back(make_item(OP_TIMER_E, 1'b1, 1'b1, 1'b1, 16'hffff));
        pending_events.push_back(make_item(OP_TIMER_F, 1'b0, 1'b0, 1'b0, 16'h0000));
        pending_events.push_back(make_item(3'd5, 1'b1, 1'b1, 1'b1, 16'hffff));
        pending_events.push_back(make_item(3'd6, 1'b0, 1'b0, 1'b0, 16'h0000));
        pending_events.push_back(make_item(OP_OTHER_HI, 1'b1, 1'b0, 1'b1, 16'h5555));
        wait_for_drain();
        program_reg(REG_T1, 32'h0000_ffff);
        program_reg(REG_T2, 32'h0000_ffff);

        // initial send opens the transaction; then E doubling at the t2 cap
        pending_events.push_back(make_item(OP_MESSAGE, 1'b1, 1'b1, 1'($urandom),
                                           16'($urandom)));
        pending_events.push_back(make_item(OP_TIMER_E, 1'b0, 1'b0, 1'b0, 16'hffff));
        pending_events.push_back(make_item(OP_TIMER_E, 1'b0, 1'b0, 1'b0, 16'h7fff));
        pending_events.push_back(make_item(OP_TIMER_E, 1'b0, 1'b0, 1'b0, 16'h8000));
        pending_events.push_back(make_item(OP_TIMER_E, 1'b1, 1'b1, 1'b1, 16'h0000));
        pending_events.push_back(make_item(OP_MESSAGE, 1'b1, 1'b1, 1'b0, 16'h0000));
        pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b1, 1'b0, 16'h0000));
        pending_events.push_back(make_item(OP_MESSAGE, 1'b1, 1'b0, 1'b0, 16'h0000));

        // trying: t2 steps through its extremes, a random value and its reset value
        t2_walk[0] = 16'hffff;
        t2_walk[1] = 16'h0000;
        t2_walk[2] = 16'($urandom);
        t2_walk[3] = T2_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                wait_for_drain();
                program_reg(REG_T2, {16'h0000, t2_walk[ph]});
            end
            for (int n = 0; n < 75; n++) pending_events.push_back(live_event(1'b0));
            if (ph == 2) begin
                // hold the sender mid-stream until every action word is back
                while (pending_events.size() > 30) @(posedge i_clk);
                hold_tx = 1'b1;
                while (tx_active || expected_actions.size() != 0) @(posedge i_clk);
                hold_tx = 1'b0;
            end
        end

        // proceeding: first provisional response, then E at t2 regardless of interval
        pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b0, 1'b1, 16'($urandom)));
        t2_walk[0] = 16'($urandom);
        t2_walk[1] = 16'h0001;
        t2_walk[2] = 16'hffff;
        for (int ph = 0; ph < 3; ph++) begin
            wait_for_drain();
            program_reg(REG_T2, {16'h0000, t2_walk[ph]});
            for (int n = 0; n < 85; n++) pending_events.push_back(live_event(1'b1));
        end

        // close the transaction one of four ways
        end_path = $urandom_range(END_VIA_LINGER, END_LIFESPAN);
        case (end_path)
            END_VIA_LINGER: begin
                wait_for_drain();
                program_reg(REG_USE_K, 32'h1);
                pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b0, 1'b0,
                                                   16'($urandom)));
                for (int n = 0; n < 50; n++) pending_events.push_back(absorbed_event());
                wait_for_drain();
                program_reg(REG_USE_K, 32'h0);
                for (int n = 0; n < 50; n++) pending_events.push_back(absorbed_event());
                pending_events.push_back(make_item($urandom_range(0, 1) ? OP_TIMER_K
                                                                        : OP_LIFESPAN,
                                                   1'($urandom), 1'($urandom), 1'($urandom),
                                                   16'($urandom)));
            end
            END_NO_LINGER: begin
                wait_for_drain();
                program_reg(REG_USE_K, 32'h0);
                pending_events.push_back(make_item(OP_MESSAGE, 1'b0, 1'b0, 1'b0,
                                                   16'($urandom)));
            end
            END_TIMER_F: begin
                pending_events.push_back(make_item(OP_TIMER_F, 1'($urandom), 1'($urandom),
                                                   1'($urandom), 16'($urandom)));
            end
            default: begin
                pending_events.push_back(make_item(OP_LIFESPAN, 1'($urandom), 1'($urandom),
                                                   1'($urandom), 16'($urandom)));
            end
        endcase

        // terminated: anything at all, under changing settings
        for (int ph = 0; ph < 3; ph++) begin
            wait_for_drain();
            case (ph)
                0: program_reg(REG_T1, 32'h0);
                1: program_reg(REG_USE_K, 32'h1);
                default: program_reg(REG_T2, {16'h0000, 16'($urandom)});
            endcase
            for (int n = 0; n < 85; n++)
                pending_events.push_back(make_item(3'($urandom), 1'($urandom), 1'($urandom),
                                                   1'($urandom), 16'($urandom)));
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_actions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
